// ----- hdl/assert_macros.svh -----
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk, off while arst_n is low
`define OAID_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define OAID_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/oaid_pkg.sv -----
// shared field widths, codes and controller/datapath interface types
package oaid_pkg;

	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int VAL_W     = 32;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 8;
	localparam int MATCH_W   = 7;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 56;
	localparam int OUT_PAD_W = M_TDATA_W - (STATUS_W + COUNT_W + VAL_W + MATCH_W);

	localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
	localparam logic [OP_W-1:0] OP_APPEND   = 3'd1;
	localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd2;
	localparam logic [OP_W-1:0] OP_DEL_LAST = 3'd3;
	localparam logic [OP_W-1:0] OP_DEL_VAL  = 3'd4;
	localparam logic [OP_W-1:0] OP_READ     = 3'd5;

	localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd2;
	localparam logic [STATUS_W-1:0] STS_BADPOS   = 3'd3;
	localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd4;

	// ram read address select
	localparam logic [1:0] RD_PTR    = 2'd0;
	localparam logic [1:0] RD_PTR_M1 = 2'd1;
	localparam logic [1:0] RD_POS    = 2'd2;

	// ram write select
	localparam logic [2:0] WR_NONE    = 3'd0;
	localparam logic [2:0] WR_UP      = 3'd1;
	localparam logic [2:0] WR_DOWN    = 3'd2;
	localparam logic [2:0] WR_VAL_PTR = 3'd3;
	localparam logic [2:0] WR_VAL_CNT = 3'd4;

	typedef struct packed {
		logic                load_item;
		logic                ptr_cnt;
		logic                ptr_pos1;
		logic                ptr_zero;
		logic                ptr_inc;
		logic                ptr_dec;
		logic                rd_en;
		logic [1:0]          rd_sel;
		logic [2:0]          wr_sel;
		logic                cnt_inc;
		logic                cnt_dec;
		logic                set_status;
		logic [STATUS_W-1:0] status;
		logic                take_rd;
		logic                take_match;
		logic                out_load;
	} oaid_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            empty;
		logic            pos_gt_cnt;
		logic            pos_ge_cnt;
		logic            ptr_gt_pos;
		logic            ptr_lt_cnt;
		logic            rd_vld;
		logic            hit;
		logic            last_rd;
		logic            out_free;
	} oaid_sts_t;

endpackage

// ----- hdl/ordered_array_insert_delete.sv -----
// top level of the ordered array store with positional insert and delete
// Usage:
//   s_axis carries one operation per transfer; s_axis_tready is high only while
//   the block is idle, so one operation is worked at a time.
//   m_axis carries one result per operation from an output register; the next
//   operation is taken while that result still waits for m_axis_tready.
// Operation flow, from accept to result valid:
//   append, delete last, unused op codes and errors found at decode finish
//   directly; read waits for the registered ram read;
//   insert at position p shifts the entries from p up by one, then writes;
//   delete at position p shifts the entries above p down by one;
//   delete value scans from index 0 and on a hit shifts as delete at that index;
//   delete value not found scans every entry below the count.
// The entry ram has one write port and one registered read port, so the shift
// walk moves one entry per cycle.
// Reset clears the count and m_axis_tvalid, s_axis_tready is high right after;
// the entries are not cleared and are only read below the count. If
// m_axis_tready stays low, the finished result holds, one more operation can be
// worked, then s_axis_tready stays low.
module ordered_array_insert_delete import oaid_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// op [2:0], position [9:3], value [41:10], zero fill
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// status [2:0], count [10:3], read_value [42:11], match_index [49:43], zero fill
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	oaid_cmd_t cmd;
	oaid_sts_t sts;

	oaid_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.s_valid(s_axis_tvalid),
		.s_ready(s_axis_tready),
		.sts    (sts),
		.cmd    (cmd)
	);

	oaid_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_axis_tdata),
		.m_tready(m_axis_tready),
		.m_tvalid(m_axis_tvalid),
		.m_tdata (m_axis_tdata),
		.cmd     (cmd),
		.sts     (sts)
	);

endmodule

// ----- hdl/oaid_ram.sv -----
// generic single-write, single-read ram with registered read data
module oaid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/oaid_ctrl.sv -----
// operation sequencer: decode, shift walks, value scan and result handoff
module oaid_ctrl import oaid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_valid,
	output logic      s_ready,
	input  oaid_sts_t sts,
	output oaid_cmd_t cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_UP     = 3'd2;
	localparam logic [2:0] S_DOWN   = 3'd3;
	localparam logic [2:0] S_SCAN   = 3'd4;
	localparam logic [2:0] S_RDWAIT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		s_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					cmd.load_item = 1'b1;
					state_d       = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (sts.op)
					OP_INSERT: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_FULL;
						end else if (sts.pos_gt_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_BADPOS;
						end else begin
							cmd.ptr_cnt = 1'b1;
							state_d     = S_UP;
						end
					end
					OP_APPEND: begin
						if (sts.full) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_FULL;
						end else begin
							cmd.wr_sel  = WR_VAL_CNT;
							cmd.cnt_inc = 1'b1;
						end
					end
					OP_DEL_POS: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_EMPTY;
						end else if (sts.pos_ge_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_BADPOS;
						end else begin
							cmd.ptr_pos1 = 1'b1;
							state_d      = S_DOWN;
						end
					end
					OP_DEL_LAST: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_EMPTY;
						end else begin
							cmd.cnt_dec = 1'b1;
						end
					end
					OP_DEL_VAL: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_EMPTY;
						end else begin
							cmd.ptr_zero = 1'b1;
							state_d      = S_SCAN;
						end
					end
					OP_READ: begin
						if (sts.empty) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_EMPTY;
						end else if (sts.pos_ge_cnt) begin
							cmd.set_status = 1'b1;
							cmd.status     = STS_BADPOS;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_POS;
							state_d    = S_RDWAIT;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_UP: begin
				// read the entry below the pointer, write it one place up in the next cycle
				if (sts.ptr_gt_pos) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PTR_M1;
					cmd.ptr_dec = 1'b1;
				end
				if (sts.rd_vld) begin
					cmd.wr_sel = WR_UP;
				end else if (!sts.ptr_gt_pos) begin
					cmd.wr_sel  = WR_VAL_PTR;
					cmd.cnt_inc = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_DOWN: begin
				if (sts.ptr_lt_cnt) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PTR;
					cmd.ptr_inc = 1'b1;
				end
				if (sts.rd_vld) begin
					cmd.wr_sel = WR_DOWN;
				end else if (!sts.ptr_lt_cnt) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_DONE;
				end
			end
			S_SCAN: begin
				// the read issued alongside a hit is the first read of the shift
				if (sts.ptr_lt_cnt) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_sel  = RD_PTR;
					cmd.ptr_inc = 1'b1;
				end
				if (sts.hit) begin
					cmd.take_match = 1'b1;
					state_d        = S_DOWN;
				end else if (sts.last_rd) begin
					cmd.set_status = 1'b1;
					cmd.status     = STS_NOTFOUND;
					state_d        = S_DONE;
				end
			end
			S_RDWAIT: begin
				cmd.take_rd = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- hdl/oaid_dp.sv -----
// datapath: entry ram, count, walk pointer, result and output registers
module oaid_dp import oaid_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic                 m_tready,
	output logic                 m_tvalid,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  oaid_cmd_t            cmd,
	output oaid_sts_t            sts
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	logic [OP_W-1:0]        op_q;
	logic [POS_W-1:0]       pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          ptr_q;
	logic [CW-1:0]          ptr_m1;
	logic                   rd_vld_s1;
	logic [IW-1:0]          rd_addr_s1;
	logic [STATUS_W-1:0]    status_q;
	logic [VAL_W-1:0]       rdval_q;
	logic [MATCH_W-1:0]     match_q;
	logic                   m_vld_q;
	logic [M_TDATA_W-1:0]   m_data_q;

	logic                   wr_en;
	logic [IW-1:0]          wr_addr;
	logic [VAL_W-1:0]       wr_data;
	logic [IW-1:0]          rd_addr;
	logic [VAL_W-1:0]       rd_data;

	logic [CMPW-1:0]        pos_ext;
	logic [CMPW-1:0]        cnt_ext;
	logic [CMPW-1:0]        ptr_ext;

	oaid_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign ptr_m1 = ptr_q - CW'(1);

	always_comb begin
		case (cmd.rd_sel)
			RD_PTR:    rd_addr = ptr_q[IW-1:0];
			RD_PTR_M1: rd_addr = ptr_m1[IW-1:0];
			RD_POS:    rd_addr = IW'(pos_q);
			default:   rd_addr = ptr_q[IW-1:0];
		endcase
	end

	always_comb begin
		wr_en   = 1'b1;
		wr_addr = ptr_q[IW-1:0];
		wr_data = val_q;
		case (cmd.wr_sel)
			WR_UP: begin
				wr_addr = rd_addr_s1 + IW'(1);
				wr_data = rd_data;
			end
			WR_DOWN: begin
				wr_addr = rd_addr_s1 - IW'(1);
				wr_data = rd_data;
			end
			WR_VAL_PTR: begin
				wr_addr = ptr_q[IW-1:0];
			end
			WR_VAL_CNT: begin
				wr_addr = cnt_q[IW-1:0];
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	assign pos_ext = CMPW'(pos_q);
	assign cnt_ext = CMPW'(cnt_q);
	assign ptr_ext = CMPW'(ptr_q);

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.full       = (cnt_q == CW'(CAPACITY));
		sts.empty      = (cnt_q == '0);
		sts.pos_gt_cnt = (pos_ext > cnt_ext);
		sts.pos_ge_cnt = (pos_ext >= cnt_ext);
		sts.ptr_gt_pos = (ptr_ext > pos_ext);
		sts.ptr_lt_cnt = (ptr_q < cnt_q);
		sts.rd_vld     = rd_vld_s1;
		sts.hit        = rd_vld_s1 && (rd_data == val_q);
		sts.last_rd    = rd_vld_s1 && ((CW'(rd_addr_s1) + CW'(1)) == cnt_q);
		sts.out_free   = !m_vld_q || m_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			ptr_q     <= '0;
			rd_vld_s1 <= 1'b0;
			m_vld_q   <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.ptr_cnt) begin
				ptr_q <= cnt_q;
			end else if (cmd.ptr_pos1) begin
				ptr_q <= CW'(pos_q) + CW'(1);
			end else if (cmd.ptr_zero) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + CW'(1);
			end else if (cmd.ptr_dec) begin
				ptr_q <= ptr_m1;
			end
			if (cmd.out_load) begin
				m_vld_q <= 1'b1;
			end else if (m_tready) begin
				m_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q     <= s_tdata[OP_W-1:0];
			pos_q    <= s_tdata[OP_W +: POS_W];
			val_q    <= s_tdata[OP_W + POS_W +: VAL_W];
			status_q <= STS_OK;
			rdval_q  <= '0;
			match_q  <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status;
			end
			if (cmd.take_rd) begin
				rdval_q <= rd_data;
			end
			if (cmd.take_match) begin
				match_q <= MATCH_W'(rd_addr_s1);
			end
		end
		if (cmd.rd_en) begin
			rd_addr_s1 <= rd_addr;
		end
		if (cmd.out_load) begin
			m_data_q <= {{OUT_PAD_W{1'b0}}, match_q, rdval_q, COUNT_W'(cnt_q), status_q};
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;

endmodule

// ----- hdl/oaid_checker.sv -----
// port-level checker for the ordered array store, bound to the top level
`include "assert_macros.svh"

module oaid_checker import oaid_pkg::*; #(
	parameter int CAPACITY = 128
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tvalid,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  count;
	logic [VAL_W-1:0]    read_value;
	logic [MATCH_W-1:0]  match_index;
	logic                s_xfer;

	assign status      = m_axis_tdata[STATUS_W-1:0];
	assign count       = m_axis_tdata[STATUS_W +: COUNT_W];
	assign read_value  = m_axis_tdata[STATUS_W + COUNT_W +: VAL_W];
	assign match_index = m_axis_tdata[STATUS_W + COUNT_W + VAL_W +: MATCH_W];
	assign s_xfer      = s_axis_tvalid && s_axis_tready;

	`OAID_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	`OAID_ASSERT(a_status_range, !m_axis_tvalid || (status <= STS_NOTFOUND), "status code out of range")
	`OAID_ASSERT(a_count_range, !m_axis_tvalid || (32'(count) <= CAPACITY), "count above capacity")
	`OAID_ASSERT(a_err_fields, !m_axis_tvalid || (status == STS_OK) || ((read_value == '0) && (match_index == '0)), "error result carries data")
	`OAID_ASSERT_NEXT(a_one_at_a_time, s_xfer, !s_axis_tready, "input taken while an operation is in work")

endmodule

bind ordered_array_insert_delete oaid_checker #(.CAPACITY(CAPACITY)) u_oaid_checker (.*);
